// ===== design/page_set_table_engine_core_assert.svh =====
// Assertion macros for the page set table engine checker.
// Expect clk and rst_n to be visible where the macros are used.
`ifndef PAGE_SET_TABLE_ENGINE_CORE_ASSERT_SVH
`define PAGE_SET_TABLE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define PSTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PSTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pste_pkg.sv =====
// Shared types and codes for the page set table engine.
// No dependencies.
package pste_pkg;

  localparam int PAGE_BITS    = 24;
  localparam int IDX_W        = 10;
  localparam int COUNT_W      = 11;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 3;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GET     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [IDX_W-1:0]     index;
    logic [PAGE_BITS-1:0] page;
    logic [PAGE_BITS-1:0] new_page;
  } pste_in_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_out;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   count;
  } pste_out_t;

endpackage

// ===== design/page_set_table_engine_core.sv =====
// Page set table engine: bounded page set with sequenced scans over the entry RAM.
// Push, set, clear and rejected requests go from the accept to S_RESP, then to the output registers.
// Pop and get pass through S_RDWAIT first (one RAM read). Replace scans in S_REP, one entry per cycle.
// Remove reads the last entry in S_RMLAST, then scans in S_RMSCAN until a match. One item at a time:
// in_ready returns as the result registers; a stalled result holds the next one in S_RESP and input off.
// Reset (sync, rst_n low) clears the count and handshake state; RAM contents are kept.
module page_set_table_engine_core #(
  parameter int CAPACITY = pste_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pste_pkg::pste_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pste_pkg::pste_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > pste_pkg::IDX_W) ? CW : pste_pkg::IDX_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_REP    = 3'd2;
  localparam logic [2:0] S_RMLAST = 3'd3;
  localparam logic [2:0] S_RMSCAN = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [AW-1:0]                  k_r, k_nxt;
  logic [pste_pkg::PAGE_BITS-1:0] last_r, last_nxt;
  logic [pste_pkg::PAGE_BITS-1:0] res_page_r, res_page_nxt;
  logic [pste_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  pste_pkg::pste_in_t             req_r, req_nxt;
  logic                           out_valid_r, out_valid_nxt;
  pste_pkg::pste_out_t            out_data_r, out_data_nxt;

  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_waddr, mem_raddr;
  logic [pste_pkg::PAGE_BITS-1:0] mem_wdata, mem_rdata;

  logic          accept;
  logic          hit;
  logic          in_range;
  logic [CW-1:0] cnt_m1;
  logic [XW-1:0] idx_x;

  pste_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(pste_pkg::PAGE_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign hit       = (mem_rdata == req_r.page);
  assign cnt_m1    = cnt_r - CW'(1);
  assign idx_x     = XW'(in_data.index);
  assign in_range  = idx_x < XW'(cnt_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    last_nxt       = last_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    req_nxt        = req_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    // output slot frees on transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt        = in_data;
          res_page_nxt   = '0;
          res_status_nxt = pste_pkg::ST_OK;
          state_nxt      = S_RESP;
          unique case (in_data.mode)
            pste_pkg::MODE_PUSH: begin
              if (cnt_r == CW'(CAPACITY)) begin
                res_status_nxt = pste_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[AW-1:0];
                mem_wdata = in_data.page;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            pste_pkg::MODE_POP: begin
              if (cnt_r == '0) begin
                res_status_nxt = pste_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m1[AW-1:0];
                cnt_nxt   = cnt_m1;
                state_nxt = S_RDWAIT;
              end
            end
            pste_pkg::MODE_GET: begin
              if (!in_range) begin
                res_status_nxt = pste_pkg::ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_x[AW-1:0];
                state_nxt = S_RDWAIT;
              end
            end
            pste_pkg::MODE_SET: begin
              if (!in_range) begin
                res_status_nxt = pste_pkg::ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_x[AW-1:0];
                mem_wdata = in_data.page;
              end
            end
            pste_pkg::MODE_REPLACE: begin
              if (cnt_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                k_nxt     = '0;
                state_nxt = S_REP;
              end
            end
            pste_pkg::MODE_REMOVE: begin
              if (cnt_r == '0) begin
                res_status_nxt = pste_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m1[AW-1:0];
                state_nxt = S_RMLAST;
              end
            end
            pste_pkg::MODE_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_page_nxt = mem_rdata;
        state_nxt    = S_RESP;
      end
      S_REP: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = k_r;
          mem_wdata = req_r.new_page;
        end
        if (CW'(k_r) + CW'(1) < cnt_r) begin
          mem_re    = 1'b1;
          mem_raddr = k_r + AW'(1);
          k_nxt     = k_r + AW'(1);
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RMLAST: begin
        last_nxt = mem_rdata;
        if (hit) begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_RESP;
        end else if (cnt_r == CW'(1)) begin
          res_status_nxt = pste_pkg::ST_NOTFOUND;
          state_nxt      = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          k_nxt     = '0;
          state_nxt = S_RMSCAN;
        end
      end
      S_RMSCAN: begin
        if (hit) begin
          // move last entry into the matching slot
          mem_we    = 1'b1;
          mem_waddr = k_r;
          mem_wdata = last_r;
          cnt_nxt   = cnt_m1;
          state_nxt = S_RESP;
        end else if (CW'(k_r) + CW'(1) < cnt_m1) begin
          mem_re    = 1'b1;
          mem_raddr = k_r + AW'(1);
          k_nxt     = k_r + AW'(1);
        end else begin
          res_status_nxt = pste_pkg::ST_NOTFOUND;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.page_out = res_page_r;
          out_data_nxt.status   = res_status_r;
          out_data_nxt.count    = pste_pkg::COUNT_W'(cnt_r);
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    last_r       <= last_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    req_r        <= req_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// ===== design/pste_ram.sv =====
// Entry store: one write port, one read port with registered read data.
// No dependencies.
module pste_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pste_checker.sv =====
// Port-level checker for page_set_table_engine_core, bound to page_set_table_engine_core.
// Depends on pste_pkg and page_set_table_engine_core_assert.svh.
`include "page_set_table_engine_core_assert.svh"

module pste_checker #(
  parameter int CAPACITY = pste_pkg::CAPACITY_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input pste_pkg::pste_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input pste_pkg::pste_out_t out_data
);

  `PSTE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `PSTE_ASSERT_NOW(a_full_count, out_valid && (out_data.status == pste_pkg::ST_FULL), out_data.count == pste_pkg::COUNT_W'(CAPACITY), "full drop with count not at capacity")
  `PSTE_ASSERT_NOW(a_empty_count, out_valid && (out_data.status == pste_pkg::ST_EMPTY), out_data.count == '0, "empty status with nonzero count")
  `PSTE_ASSERT_NOW(a_err_page_zero, out_valid && (out_data.status != pste_pkg::ST_OK), out_data.page_out == '0, "error result with nonzero page")
  `PSTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind page_set_table_engine_core pste_checker #(.CAPACITY(CAPACITY)) u_pste_checker (.*);
